[hw/rtl/lchw_pkg.sv]
`default_nettype none
package lchw_pkg;

    // Default digit radices. Port widths of the region and group digits follow from these.
    localparam int unsigned LCHW_REGION_RADIX = 1024;
    localparam int unsigned LCHW_GROUP_RADIX  = 1024;

    localparam int unsigned LCHW_WORD_W = 64;
    localparam int unsigned LCHW_WARP_W = 53;

    // Chained rounds ahead of the two output rounds: the seed round, then six per axis.
    localparam int unsigned LCHW_CHAIN_ROUNDS = 13;

    localparam logic [63:0] LCHW_GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] LCHW_MUL_ONE     = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] LCHW_MUL_TWO     = 64'h94D0_49BB_1331_11EB;
    localparam logic [63:0] LCHW_SEED_SALT   = 64'h4D41_4352_4F32_5741;
    localparam logic [63:0] LCHW_TAG_X       = 64'hA24B_AED4_963E_E407;
    localparam logic [63:0] LCHW_TAG_Z       = 64'h9FB2_1C65_1E98_DF25;
    localparam logic [63:0] LCHW_OUT_SALT_X  = 64'h5857_4152_504C_4F57;
    localparam logic [63:0] LCHW_OUT_SALT_Z  = 64'h5A57_4152_504C_4F57;

endpackage
`default_nettype wire

[hw/rtl/lattice_corner_hash_warp.sv]
// Pipeline: an accepted input transaction passes through 15 finalizer rounds of 5 stages each,
// then the output register, to its result on the master side.
// Throughput: one corner per cycle while the skid slot is empty; each round is fully pipelined.
// Reset (synchronous, active low): clears all valid bits, the skid slot and world_seed to 0.
`default_nettype none
module lattice_corner_hash_warp
    import lchw_pkg::*;
#(
    parameter int unsigned REGION_RADIX = LCHW_REGION_RADIX,
    parameter int unsigned GROUP_RADIX  = LCHW_GROUP_RADIX,
    localparam int unsigned REGION_W    = $clog2(REGION_RADIX),
    localparam int unsigned GROUP_W     = $clog2(GROUP_RADIX),
    localparam int unsigned ITEM_W      = 2 * (LCHW_WORD_W + REGION_W + GROUP_W),
    localparam int unsigned IN_TDATA_W  = ((ITEM_W + 7) / 8) * 8,
    localparam int unsigned RES_W       = 2 * LCHW_WARP_W,
    localparam int unsigned OUT_TDATA_W = ((RES_W + 7) / 8) * 8
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    // configuration: world_seed
    input  wire                      i_cfg_we,
    input  wire  [LCHW_WORD_W-1:0]   i_cfg_wdata,
    // corner input
    input  wire                      s_axis_tvalid,
    output logic                     s_axis_tready,
    // low to high: x_sector, x_region, x_group, z_sector, z_region, z_group
    input  wire  [IN_TDATA_W-1:0]    s_axis_tdata,
    // warp output
    output logic                     m_axis_tvalid,
    input  wire                      m_axis_tready,
    // low to high: warp_x, warp_z, zero pad
    output logic [OUT_TDATA_W-1:0]   m_axis_tdata
);

    // Field offsets inside the packed item.
    localparam int unsigned XS_LO = 0;
    localparam int unsigned XR_LO = XS_LO + LCHW_WORD_W;
    localparam int unsigned XG_LO = XR_LO + REGION_W;
    localparam int unsigned ZS_LO = XG_LO + GROUP_W;
    localparam int unsigned ZR_LO = ZS_LO + LCHW_WORD_W;
    localparam int unsigned ZG_LO = ZR_LO + REGION_W;

    logic [LCHW_WORD_W-1:0] r_seed;

    // The whole pipeline advances together; it only holds while the skid slot is occupied.
    logic w_en;

    // Chain of rounds: index k is the input of round k.
    logic                   w_valid [LCHW_CHAIN_ROUNDS+1];
    logic [LCHW_WORD_W-1:0] w_acc   [LCHW_CHAIN_ROUNDS+1];
    logic [ITEM_W-1:0]      w_item  [LCHW_CHAIN_ROUNDS+1];

    // Output rounds: the x round carries the final chain value forward for the z round.
    logic                   w_xr_valid;
    logic [LCHW_WORD_W-1:0] w_xr_mix;
    logic [LCHW_WORD_W-1:0] w_xr_chain;
    logic                   w_tail_valid;
    logic [LCHW_WORD_W-1:0] w_zr_mix;
    logic [LCHW_WORD_W-1:0] w_tail_xmix;
    logic [RES_W-1:0]       w_tail_data;

    logic             r_out_valid;
    logic [RES_W-1:0] r_out_data;
    logic             r_skid_valid;
    logic [RES_W-1:0] r_skid_data;
    logic             n_out_valid;
    logic [RES_W-1:0] n_out_data;
    logic             n_skid_valid;
    logic [RES_W-1:0] n_skid_data;

    assign w_en          = !r_skid_valid;
    assign s_axis_tready = w_en;

    // Seed register; the user must write it only while the block is idle (not enforced here).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
        end
    end

    // The seed round mixes world_seed ^ SEED_SALT; the item rides along as side data.
    assign w_valid[0] = s_axis_tvalid;
    assign w_acc[0]   = r_seed;
    assign w_item[0]  = s_axis_tdata[ITEM_W-1:0];

    // Round order: seed, x tag, x sector, x region, x group, two zero digits,
    // z tag, z sector, z region, z group, two zero digits.
    for (genvar k = 0; k < LCHW_CHAIN_ROUNDS; k++) begin : g_chain
        logic [LCHW_WORD_W-1:0] w_key;

        if (k == 0) begin : g_seed
            assign w_key = LCHW_SEED_SALT;
        end else if (k == 1) begin : g_xtag
            assign w_key = LCHW_TAG_X;
        end else if (k == 2) begin : g_xs
            assign w_key = w_item[k][XS_LO +: LCHW_WORD_W];
        end else if (k == 3) begin : g_xr
            assign w_key = LCHW_WORD_W'(w_item[k][XR_LO +: REGION_W]);
        end else if (k == 4) begin : g_xg
            assign w_key = LCHW_WORD_W'(w_item[k][XG_LO +: GROUP_W]);
        end else if (k == 7) begin : g_ztag
            assign w_key = LCHW_TAG_Z;
        end else if (k == 8) begin : g_zs
            assign w_key = w_item[k][ZS_LO +: LCHW_WORD_W];
        end else if (k == 9) begin : g_zr
            assign w_key = LCHW_WORD_W'(w_item[k][ZR_LO +: REGION_W]);
        end else if (k == 10) begin : g_zg
            assign w_key = LCHW_WORD_W'(w_item[k][ZG_LO +: GROUP_W]);
        end else begin : g_zero
            // chunk and block digits are always zero
            assign w_key = '0;
        end

        lchw_round #(
            .SIDE_W (ITEM_W)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k]),
            .i_acc   (w_acc[k]),
            .i_key   (w_key),
            .i_side  (w_item[k]),
            .o_valid (w_valid[k+1]),
            .o_acc   (w_acc[k+1]),
            .o_side  (w_item[k+1])
        );
    end

    // x output round; the chain value rides as side data.
    lchw_round #(
        .SIDE_W (LCHW_WORD_W)
    ) u_round_out_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_valid[LCHW_CHAIN_ROUNDS]),
        .i_acc   (w_acc[LCHW_CHAIN_ROUNDS]),
        .i_key   (LCHW_OUT_SALT_X),
        .i_side  (w_acc[LCHW_CHAIN_ROUNDS]),
        .o_valid (w_xr_valid),
        .o_acc   (w_xr_mix),
        .o_side  (w_xr_chain)
    );

    // z output round on the same chain value; the x mix rides as side data.
    lchw_round #(
        .SIDE_W (LCHW_WORD_W)
    ) u_round_out_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_xr_valid),
        .i_acc   (w_xr_chain),
        .i_key   (LCHW_OUT_SALT_Z),
        .i_side  (w_xr_mix),
        .o_valid (w_tail_valid),
        .o_acc   (w_zr_mix),
        .o_side  (w_tail_xmix)
    );

    // Keep the top 53 bits and subtract 2^52: flip the top bit.
    assign w_tail_data = {
        ~w_zr_mix[LCHW_WORD_W-1],    w_zr_mix[LCHW_WORD_W-2 -: LCHW_WARP_W-1],
        ~w_tail_xmix[LCHW_WORD_W-1], w_tail_xmix[LCHW_WORD_W-2 -: LCHW_WARP_W-1]
    };

    // Output register plus skid slot. The tail of the pipeline is consumed in
    // every cycle in which w_en is high; a result that finds the output
    // register stalled parks in the skid slot, which then holds the pipeline.
    // While the slot is occupied the tail is held in place, not consumed.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = w_tail_valid;
                n_out_data  = w_tail_data;
            end
        end else if (w_tail_valid && !r_skid_valid) begin
            n_skid_valid = 1'b1;
            n_skid_data  = w_tail_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_data);

endmodule
`default_nettype wire

[hw/rtl/lchw_round.sv]
`default_nettype none
// One splitmix64 finalizer round on (acc ^ key), five register stages.
// Each 64-bit product is split into three 32x32 partial products, summed one stage later.
module lchw_round
    import lchw_pkg::*;
#(
    parameter int unsigned SIDE_W = 64
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_en,
    input  wire                      i_valid,
    input  wire  [LCHW_WORD_W-1:0]   i_acc,
    input  wire  [LCHW_WORD_W-1:0]   i_key,
    input  wire  [SIDE_W-1:0]        i_side,
    output logic                     o_valid,
    output logic [LCHW_WORD_W-1:0]   o_acc,
    output logic [SIDE_W-1:0]        o_side
);

    logic [4:0]        r_valid;
    logic [SIDE_W-1:0] r_side [5];

    logic [63:0] r_s1_w;
    logic [63:0] r_s2_p0;
    logic [31:0] r_s2_p1;
    logic [31:0] r_s2_p2;
    logic [63:0] r_s3_w;
    logic [63:0] r_s4_p0;
    logic [31:0] r_s4_p1;
    logic [31:0] r_s4_p2;
    logic [63:0] r_s5_out;

    logic [63:0] n_s1_w;
    logic [63:0] n_s3_w;
    logic [63:0] n_s5_out;
    logic [63:0] w_v;
    logic [63:0] w_y1;
    logic [63:0] w_y2;

    always_comb begin
        w_v      = (i_acc ^ i_key) + LCHW_GOLDEN_STEP;
        n_s1_w   = w_v ^ (w_v >> 30);
        w_y1     = r_s2_p0 + {r_s2_p1 + r_s2_p2, 32'b0};
        n_s3_w   = w_y1 ^ (w_y1 >> 27);
        w_y2     = r_s4_p0 + {r_s4_p1 + r_s4_p2, 32'b0};
        n_s5_out = w_y2 ^ (w_y2 >> 31);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_side[1] <= r_side[0];
            r_side[2] <= r_side[1];
            r_side[3] <= r_side[2];
            r_side[4] <= r_side[3];

            r_s1_w   <= n_s1_w;
            r_s2_p0  <= {32'b0, r_s1_w[31:0]} * {32'b0, LCHW_MUL_ONE[31:0]};
            r_s2_p1  <= r_s1_w[31:0] * LCHW_MUL_ONE[63:32];
            r_s2_p2  <= r_s1_w[63:32] * LCHW_MUL_ONE[31:0];
            r_s3_w   <= n_s3_w;
            r_s4_p0  <= {32'b0, r_s3_w[31:0]} * {32'b0, LCHW_MUL_TWO[31:0]};
            r_s4_p1  <= r_s3_w[31:0] * LCHW_MUL_TWO[63:32];
            r_s4_p2  <= r_s3_w[63:32] * LCHW_MUL_TWO[31:0];
            r_s5_out <= n_s5_out;
        end
    end

    assign o_valid = r_valid[4];
    assign o_acc   = r_s5_out;
    assign o_side  = r_side[4];

endmodule
`default_nettype wire

[bench/lchw_warp_checker.sv]
`timescale 1ns / 1ps
module lchw_warp_checker
    import lchw_pkg::*;
#(
    parameter int unsigned CORNER_W = 168,
    parameter int unsigned WARP_W   = 112
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire  [LCHW_WORD_W-1:0] i_cfg_wdata,
    input  wire                    i_corner_valid,
    input  wire                    i_corner_ready,
    input  wire  [CORNER_W-1:0]    i_corner_data,
    input  wire                    i_warp_valid,
    input  wire                    i_warp_ready,
    input  wire  [WARP_W-1:0]      i_warp_data,
    output int                     o_warps_owed,
    output int                     o_fail_count
);

    typedef struct packed {
        logic [LCHW_WARP_W-1:0] warp_z;
        logic [LCHW_WARP_W-1:0] warp_x;
    } t_warp_pair;

    logic [LCHW_WORD_W-1:0] seed_shadow;
    t_warp_pair             warp_expected_q[$];

    function automatic logic [63:0] splitmix_round(input logic [63:0] v);
        logic [63:0] t;
        t = v + LCHW_GOLDEN_STEP;
        t = (t ^ (t >> 30)) * LCHW_MUL_ONE;
        t = (t ^ (t >> 27)) * LCHW_MUL_TWO;
        return t ^ (t >> 31);
    endfunction

    function automatic logic [63:0] fold_coordinate(input logic [63:0] acc,
                                                    input logic [63:0] tag,
                                                    input logic [63:0] sector,
                                                    input logic [9:0]  region,
                                                    input logic [9:0]  group_digit);
        logic [63:0] h;
        h = splitmix_round(acc ^ tag);
        h = splitmix_round(h ^ sector);
        h = splitmix_round(h ^ {54'd0, region});
        h = splitmix_round(h ^ {54'd0, group_digit});
        // chunk and block digits are zero
        h = splitmix_round(h);
        return splitmix_round(h);
    endfunction

    // Top 53 bits of the salted mix, offset by -1.0: just flip the sign bit.
    function automatic logic [LCHW_WARP_W-1:0] warp_from_mix(input logic [63:0] acc,
                                                            input logic [63:0] salt);
        logic [63:0] r;
        r = splitmix_round(acc ^ salt);
        return {~r[63], r[62:11]};
    endfunction

    function automatic t_warp_pair corner_warp(input logic [63:0]         seed,
                                               input logic [CORNER_W-1:0] d);
        logic [63:0] acc;
        t_warp_pair  w;
        acc = splitmix_round(seed ^ LCHW_SEED_SALT);
        acc = fold_coordinate(acc, LCHW_TAG_X, d[63:0], d[73:64], d[83:74]);
        acc = fold_coordinate(acc, LCHW_TAG_Z, d[147:84], d[157:148], d[167:158]);
        w.warp_x = warp_from_mix(acc, LCHW_OUT_SALT_X);
        w.warp_z = warp_from_mix(acc, LCHW_OUT_SALT_Z);
        return w;
    endfunction

    initial begin
        o_warps_owed = 0;
        o_fail_count = 0;
    end

    always @(posedge i_clk) begin
        t_warp_pair want;
        t_warp_pair got;
        if (!i_rst_n) begin
            seed_shadow <= '0;
            warp_expected_q.delete();
        end else begin
            // predict with the seed in force before this edge
            if (i_corner_valid && i_corner_ready) begin
                warp_expected_q.push_back(corner_warp(seed_shadow, i_corner_data));
            end
            if (i_warp_valid && i_warp_ready) begin
                got = i_warp_data[2*LCHW_WARP_W-1:0];
                if (warp_expected_q.size() == 0) begin
                    $error("unexpected warp transaction: data %0h", i_warp_data);
                    o_fail_count++;
                end else begin
                    want = warp_expected_q.pop_front();
                    if (got.warp_x !== want.warp_x) begin
                        $error("warp_x mismatch: expected %0h, got %0h",
                               want.warp_x, got.warp_x);
                        o_fail_count++;
                    end
                    if (got.warp_z !== want.warp_z) begin
                        $error("warp_z mismatch: expected %0h, got %0h",
                               want.warp_z, got.warp_z);
                        o_fail_count++;
                    end
                end
                if (i_warp_data[WARP_W-1:2*LCHW_WARP_W] !== '0) begin
                    $error("pad mismatch: expected 0, got %0h",
                           i_warp_data[WARP_W-1:2*LCHW_WARP_W]);
                    o_fail_count++;
                end
            end
            if (i_cfg_we) begin
                seed_shadow <= i_cfg_wdata;
            end
        end
        o_warps_owed = warp_expected_q.size();
    end

endmodule

[bench/lattice_corner_hash_warp_tb.sv]
`timescale 1ns / 1ps
module lattice_corner_hash_warp_tb
    import lchw_pkg::*;
;

    localparam int unsigned DIGIT_W   = $clog2(LCHW_REGION_RADIX);
    localparam int unsigned CORNER_W  = 2 * (LCHW_WORD_W + 2 * DIGIT_W);
    localparam int unsigned WARP_W    = ((2 * LCHW_WARP_W + 7) / 8) * 8;
    localparam int unsigned RESET_CYCLES   = 11;
    localparam int unsigned CYCLE_LIMIT    = 200_000;
    // pipeline is 76 deep; let it run dry after the last result
    localparam int unsigned DRAIN_TAIL     = 100;
    localparam int unsigned ITEMS_PER_SEED = 113;
    // start the long receiver hold-off in the middle of the second random phase
    localparam int unsigned HOLDOFF_AT     = 180;
    localparam int unsigned HOLDOFF_CYCLES = 400;

    localparam logic [63:0] SECTOR_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] SECTOR_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SECTOR_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] CHECKER_A   = 64'h5555_5555_5555_5555;
    localparam logic [63:0] CHECKER_B   = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [9:0]  DIGIT_TOP   = 10'd1023;

    typedef enum int {
        DRAIN_FREE,
        DRAIN_RANDOM,
        DRAIN_CADENCE,
        DRAIN_SPARSE
    } t_drain_mode;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [LCHW_WORD_W-1:0] i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // low to high: x_sector, x_region, x_group, z_sector, z_region, z_group
    logic [CORNER_W-1:0]    s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // low to high: warp_x, warp_z, zero pad
    logic [WARP_W-1:0]      m_axis_tdata;

    int warps_owed;
    int fail_count;
    int corners_sent;
    int burst_left;
    int cycle_count;

    lattice_corner_hash_warp dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lchw_warp_checker #(
        .CORNER_W (CORNER_W),
        .WARP_W   (WARP_W)
    ) warp_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_corner_valid (s_axis_tvalid),
        .i_corner_ready (s_axis_tready),
        .i_corner_data  (s_axis_tdata),
        .i_warp_valid   (m_axis_tvalid),
        .i_warp_ready   (m_axis_tready),
        .i_warp_data    (m_axis_tdata),
        .o_warps_owed   (warps_owed),
        .o_fail_count   (fail_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Offer one corner and hold it until the block takes it. Between bursts,
    // drop valid for a random gap; inside a burst the next corner follows
    // back to back, so valid only gets one assignment per step.
    task automatic send_corner(input logic [63:0] x_sector, input logic [9:0] x_region,
                               input logic [9:0] x_group, input logic [63:0] z_sector,
                               input logic [9:0] z_region, input logic [9:0] z_group);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z_group, z_region, z_sector, x_group, x_region, x_sector};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        corners_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 40);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    function automatic logic [63:0] pick_sector();
        case ($urandom_range(0, 7))
            0:       return 64'($signed($urandom_range(0, 8)) - 4);
            1:       return SECTOR_MIN + 64'($urandom_range(0, 3));
            2:       return SECTOR_MAX - 64'($urandom_range(0, 3));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [9:0] pick_digit();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return DIGIT_TOP;
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    // Wait until every corner in flight has come out, then load a new seed.
    // The first edge lets the checker record the last accepted corner.
    task automatic reseed(input logic [63:0] seed);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (warps_owed != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= seed;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_corners(input int count);
        repeat (count) begin
            send_corner(pick_sector(), pick_digit(), pick_digit(),
                        pick_sector(), pick_digit(), pick_digit());
        end
    endtask

    // Receiver: segments of random length in one of several stall patterns,
    // plus one long hold-off so the pipe backs up into the input side.
    initial begin : drain
        t_drain_mode mode;
        int          seg_len;
        bit          holdoff_done;
        holdoff_done  = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            if (!holdoff_done && corners_sent >= HOLDOFF_AT) begin
                holdoff_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            end
            mode    = t_drain_mode'($urandom_range(0, 3));
            seg_len = $urandom_range(4, 60);
            for (int k = 0; k < seg_len; k++) begin
                case (mode)
                    DRAIN_FREE:    m_axis_tready <= 1'b1;
                    DRAIN_RANDOM:  m_axis_tready <= ($urandom_range(0, 2) != 0);
                    DRAIN_CADENCE: m_axis_tready <= ((k % 4) != 3);
                    default:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("lattice_corner_hash_warp regression: fail");
        $finish;
    end

    initial begin : stimulus
        corners_sent  = 0;
        burst_left    = 0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners under the reset seed: field extremes, single
        // digits lit on each axis, x/z swapped, alternating bit patterns.
        send_corner('0, '0, '0, '0, '0, '0);
        send_corner(SECTOR_ONES, DIGIT_TOP, DIGIT_TOP, SECTOR_ONES, DIGIT_TOP, DIGIT_TOP);
        send_corner(SECTOR_MIN, '0, '0, SECTOR_MAX, '0, '0);
        send_corner(SECTOR_MAX, '0, '0, SECTOR_MIN, '0, '0);
        send_corner(64'd1, '0, '0, '0, '0, '0);
        send_corner('0, '0, '0, 64'd1, '0, '0);
        send_corner('0, 10'd1, '0, '0, '0, '0);
        send_corner('0, '0, 10'd1, '0, '0, '0);
        send_corner('0, '0, '0, '0, 10'd1, '0);
        send_corner('0, '0, '0, '0, '0, 10'd1);
        send_corner('0, DIGIT_TOP, '0, '0, '0, DIGIT_TOP);
        send_corner('0, '0, DIGIT_TOP, '0, DIGIT_TOP, '0);
        send_corner(SECTOR_ONES, '0, '0, SECTOR_ONES, '0, '0);
        send_corner(CHECKER_A, 10'h2AA, 10'h155, CHECKER_B, 10'h155, 10'h2AA);
        send_corner(CHECKER_B, 10'h155, 10'h2AA, CHECKER_A, 10'h2AA, 10'h155);
        send_corner('0, 10'd512, 10'd512, '0, 10'd512, 10'd512);
        // repeat an earlier corner: no state may carry over
        send_corner(SECTOR_ONES, DIGIT_TOP, DIGIT_TOP, SECTOR_ONES, DIGIT_TOP, DIGIT_TOP);

        // Random corners under several seeds, the extremes among them.
        reseed(SECTOR_ONES);
        random_corners(ITEMS_PER_SEED);
        reseed({$urandom, $urandom});
        random_corners(ITEMS_PER_SEED);
        reseed('0);
        random_corners(ITEMS_PER_SEED);
        reseed({$urandom, $urandom});
        send_corner('0, '0, '0, '0, '0, '0);
        random_corners(ITEMS_PER_SEED);

        // Let everything drain, then give the pipe time to show strays.
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (warps_owed != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("lattice_corner_hash_warp regression: pass");
        end else begin
            $display("lattice_corner_hash_warp regression: fail");
        end
        $finish;
    end

endmodule

[lattice_corner_hash_warp.f]
hw/rtl/lchw_pkg.sv
hw/rtl/lchw_round.sv
hw/rtl/lattice_corner_hash_warp.sv
bench/lchw_warp_checker.sv
bench/lattice_corner_hash_warp_tb.sv
